[rtl/dws_pkg.sv]
// ----------------------------------------------------------------------------
// Differential drive wheel speed package
// Payload types, field widths, fixed-point constants and register codes
// ----------------------------------------------------------------------------
package dws_pkg;

    // field and register widths
    localparam int VEL_W        = 16;
    localparam int TRACK_W      = 12;
    localparam int RADIUS_W     = 10;
    localparam int RPM_W        = 32;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int REG_SEL_BIT  = 2;

    // register reset values
    localparam int TRACK_RESET  = 620;
    localparam int RADIUS_RESET = 65;

    // fixed-point constants
    localparam int VEL_LIMIT     = 25600;
    localparam int VEL_SCALE     = 2000;
    localparam int INV_PI_30_Q16 = 625819;
    localparam int DEN_SHIFT     = 17;

    // internal datapath widths
    localparam int SQ_W     = 30;
    localparam int ISQ_IN_W = 32;
    localparam int ROOT_W   = ISQ_IN_W / 2;
    localparam int TURN_W   = 28;
    localparam int SUM_W    = 29;
    localparam int NUM_W    = 49;
    localparam int MAG_W    = 30;

    // pipeline shape defaults
    localparam int SQRT_BITS_PER_STAGE = 2;
    localparam int DIV_BITS_PER_STAGE  = 5;

    typedef enum logic {
        REG_TRACK_WIDTH  = 1'b0,
        REG_WHEEL_RADIUS = 1'b1
    } dws_reg_idx_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] linear_x;
        logic signed [VEL_W-1:0] linear_y;
        logic signed [VEL_W-1:0] angular_z;
    } dws_in_t;

    typedef struct packed {
        logic signed [RPM_W-1:0] left_rpm;
        logic signed [RPM_W-1:0] right_rpm;
    } dws_out_t;

    function automatic logic signed [VEL_W-1:0] clamp_vel(input logic signed [VEL_W-1:0] v);
        logic signed [VEL_W-1:0] r;
        r = v;
        if (v > VEL_LIMIT) begin
            r = VEL_W'(VEL_LIMIT);
        end else if (v < -VEL_LIMIT) begin
            r = VEL_W'(-VEL_LIMIT);
        end
        return r;
    endfunction

endpackage

[rtl/dws_isqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, a fixed number of result bits per register stage
// ----------------------------------------------------------------------------
module dws_isqrt import dws_pkg::*; #(
    parameter int IN_W           = ISQ_IN_W,
    parameter int BITS_PER_STAGE = SQRT_BITS_PER_STAGE,
    parameter int SIDE_W         = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     in_value,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int RT_W  = IN_W / 2;
    localparam int NST   = (RT_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int PAD_W = NST * BITS_PER_STAGE;
    localparam int RAD_W = 2 * PAD_W;
    localparam int REM_W = PAD_W + 2;

    logic              valid_reg [NST];
    logic [RAD_W-1:0]  rad_reg   [NST];
    logic [REM_W-1:0]  rem_reg   [NST];
    logic [PAD_W-1:0]  root_reg  [NST];
    logic [SIDE_W-1:0] side_reg  [NST];

    for (genvar s = 0; s < NST; s++) begin : g_stage
        logic              valid_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [PAD_W-1:0]  root_in;
        logic [SIDE_W-1:0] side_in;
        logic [RAD_W-1:0]  rad_next;
        logic [REM_W-1:0]  rem_next;
        logic [PAD_W-1:0]  root_next;

        if (s == 0) begin : g_first
            assign valid_in = in_valid;
            assign rad_in   = RAD_W'(in_value);
            assign rem_in   = '0;
            assign root_in  = '0;
            assign side_in  = in_side;
        end else begin : g_later
            assign valid_in = valid_reg[s-1];
            assign rad_in   = rad_reg[s-1];
            assign rem_in   = rem_reg[s-1];
            assign root_in  = root_reg[s-1];
            assign side_in  = side_reg[s-1];
        end

        always_comb begin
            logic [REM_W-1:0] trial;
            rad_next  = rad_in;
            rem_next  = rem_in;
            root_next = root_in;
            for (int k = 0; k < BITS_PER_STAGE; k++) begin
                rem_next = {rem_next[REM_W-3:0], rad_next[RAD_W-1 -: 2]};
                rad_next = rad_next << 2;
                trial    = {root_next, 2'b01};
                if (rem_next >= trial) begin
                    rem_next  = rem_next - trial;
                    root_next = {root_next[PAD_W-2:0], 1'b1};
                end else begin
                    root_next = {root_next[PAD_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[s]  <= rad_next;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_root  = root_reg[NST-1][RT_W-1:0];
    assign out_side  = side_reg[NST-1];

endmodule

[rtl/dws_div.sv]
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, a fixed number of quotient bits per register stage
// ----------------------------------------------------------------------------
module dws_div import dws_pkg::*; #(
    parameter int DIVIDEND_W     = MAG_W,
    parameter int DIVISOR_W      = RADIUS_W,
    parameter int BITS_PER_STAGE = DIV_BITS_PER_STAGE,
    parameter int SIDE_W         = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [DIVIDEND_W-1:0] in_dividend,
    input  logic [DIVISOR_W-1:0]  in_divisor,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [DIVIDEND_W-1:0] out_quotient,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int NST   = (DIVIDEND_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int PAD_W = NST * BITS_PER_STAGE;
    localparam int REM_W = DIVISOR_W + 1;

    logic                 valid_reg [NST];
    logic [PAD_W-1:0]     num_reg   [NST];
    logic [REM_W-1:0]     rem_reg   [NST];
    logic [PAD_W-1:0]     quot_reg  [NST];
    logic [DIVISOR_W-1:0] dvs_reg   [NST];
    logic [SIDE_W-1:0]    side_reg  [NST];

    for (genvar s = 0; s < NST; s++) begin : g_stage
        logic                 valid_in;
        logic [PAD_W-1:0]     num_in;
        logic [REM_W-1:0]     rem_in;
        logic [PAD_W-1:0]     quot_in;
        logic [DIVISOR_W-1:0] dvs_in;
        logic [SIDE_W-1:0]    side_in;
        logic [PAD_W-1:0]     num_next;
        logic [REM_W-1:0]     rem_next;
        logic [PAD_W-1:0]     quot_next;

        if (s == 0) begin : g_first
            assign valid_in = in_valid;
            assign num_in   = PAD_W'(in_dividend);
            assign rem_in   = '0;
            assign quot_in  = '0;
            assign dvs_in   = in_divisor;
            assign side_in  = in_side;
        end else begin : g_later
            assign valid_in = valid_reg[s-1];
            assign num_in   = num_reg[s-1];
            assign rem_in   = rem_reg[s-1];
            assign quot_in  = quot_reg[s-1];
            assign dvs_in   = dvs_reg[s-1];
            assign side_in  = side_reg[s-1];
        end

        always_comb begin
            logic [REM_W-1:0] dvs_ext;
            dvs_ext   = {1'b0, dvs_in};
            num_next  = num_in;
            rem_next  = rem_in;
            quot_next = quot_in;
            for (int k = 0; k < BITS_PER_STAGE; k++) begin
                rem_next = {rem_next[REM_W-2:0], num_next[PAD_W-1]};
                num_next = num_next << 1;
                if (rem_next >= dvs_ext) begin
                    rem_next  = rem_next - dvs_ext;
                    quot_next = {quot_next[PAD_W-2:0], 1'b1};
                end else begin
                    quot_next = {quot_next[PAD_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[s]  <= num_next;
                rem_reg[s]  <= rem_next;
                quot_reg[s] <= quot_next;
                dvs_reg[s]  <= dvs_in;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid    = valid_reg[NST-1];
    assign out_quotient = quot_reg[NST-1][DIVIDEND_W-1:0];
    assign out_side     = side_reg[NST-1];

endmodule

[rtl/dws_obuf.sv]
// ----------------------------------------------------------------------------
// Output buffer
// Two-entry result buffer, output register plus skid entry
// ----------------------------------------------------------------------------
module dws_obuf import dws_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  dws_out_t push_data,
    output logic     full,
    output logic     m_valid,
    input  logic     m_ready,
    output dws_out_t m_data
);

    logic     main_valid_reg, main_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    dws_out_t main_data_reg, main_data_next;
    dws_out_t skid_data_reg, skid_data_next;
    logic     pop;

    always_comb begin
        pop             = main_valid_reg & m_ready;
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end else begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full    = skid_valid_reg;
    assign m_valid = main_valid_reg;
    assign m_data  = main_data_reg;

endmodule

[rtl/diff_drive_wheel_speed.sv]
// ----------------------------------------------------------------------------
// Differential drive wheel speed
// Left and right wheel rpm from a linear x, linear y, angular z command
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is taken every clock cycle while the result
// side keeps up. The depth from input transaction to result valid is set by
// the clamp, square, sum, signed scale, rpm scale and magnitude registers, the
// square root stages (SQRT_BITS root bits per stage), the two dividers by wheel
// radius (DIV_BITS quotient bits per stage) and the output register. A two-entry
// output buffer lets input continue while one result waits. Registers: track
// width at byte address 0, wheel radius at 4.
// ----------------------------------------------------------------------------
module diff_drive_wheel_speed import dws_pkg::*; #(
    parameter int SQRT_BITS = SQRT_BITS_PER_STAGE,
    parameter int DIV_BITS  = DIV_BITS_PER_STAGE
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dws_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dws_out_t              m_data
);

    localparam logic signed [SUM_W-1:0] VEL_SCALE_S = SUM_W'(VEL_SCALE);
    localparam logic signed [NUM_W-1:0] INV_PI_S    = NUM_W'(INV_PI_30_Q16);

    // configuration registers
    logic [TRACK_W-1:0]  track_width_reg;
    logic [RADIUS_W-1:0] wheel_radius_reg;
    dws_reg_idx_t        reg_idx;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = dws_reg_idx_t'(paddr[REG_SEL_BIT]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_width_reg  <= TRACK_W'(TRACK_RESET);
            wheel_radius_reg <= RADIUS_W'(RADIUS_RESET);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_TRACK_WIDTH: begin
                    track_width_reg <= pwdata[TRACK_W-1:0];
                end
                REG_WHEEL_RADIUS: begin
                    wheel_radius_reg <= pwdata[RADIUS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TRACK_WIDTH:  prdata = CFG_DATA_W'(track_width_reg);
            REG_WHEEL_RADIUS: prdata = CFG_DATA_W'(wheel_radius_reg);
            default:          prdata = '0;
        endcase
    end

    // pipeline advance
    logic obuf_full;
    logic en;

    assign en      = ~obuf_full;
    assign s_ready = en;

    // stage 1: clamp
    logic                    v1_valid_reg;
    logic signed [VEL_W-1:0] vx1_reg, vy1_reg, wz1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_valid_reg <= 1'b0;
        end else if (en) begin
            v1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vx1_reg <= clamp_vel(s_data.linear_x);
            vy1_reg <= clamp_vel(s_data.linear_y);
            wz1_reg <= clamp_vel(s_data.angular_z);
        end
    end

    // stage 2: squares and turn term
    logic                     v2_valid_reg;
    logic [SQ_W-1:0]          sqx2_reg, sqy2_reg;
    logic signed [TURN_W-1:0] turn2_reg;
    logic                     neg2_reg;
    logic signed [2*VEL_W-1:0]      sqx_full, sqy_full;
    logic signed [TRACK_W+VEL_W:0]  turn_full;

    assign sqx_full  = vx1_reg * vx1_reg;
    assign sqy_full  = vy1_reg * vy1_reg;
    assign turn_full = $signed({1'b0, track_width_reg}) * wz1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_valid_reg <= 1'b0;
        end else if (en) begin
            v2_valid_reg <= v1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx2_reg  <= sqx_full[SQ_W-1:0];
            sqy2_reg  <= sqy_full[SQ_W-1:0];
            turn2_reg <= turn_full[TURN_W-1:0];
            neg2_reg  <= vx1_reg[VEL_W-1] | vy1_reg[VEL_W-1];
        end
    end

    // stage 3: sum of squares
    logic                     v3_valid_reg;
    logic [ISQ_IN_W-1:0]      sum3_reg;
    logic signed [TURN_W-1:0] turn3_reg;
    logic                     neg3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_valid_reg <= 1'b0;
        end else if (en) begin
            v3_valid_reg <= v2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum3_reg  <= ISQ_IN_W'(sqx2_reg) + ISQ_IN_W'(sqy2_reg);
            turn3_reg <= turn2_reg;
            neg3_reg  <= neg2_reg;
        end
    end

    // square root stages
    logic                sq_valid;
    logic [ROOT_W-1:0]   sq_root;
    logic [TURN_W:0]     sq_side;
    logic                sq_neg;
    logic signed [TURN_W-1:0] sq_turn;

    dws_isqrt #(
        .IN_W           (ISQ_IN_W),
        .BITS_PER_STAGE (SQRT_BITS),
        .SIDE_W         (TURN_W + 1)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_valid_reg),
        .in_value  (sum3_reg),
        .in_side   ({neg3_reg, turn3_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign sq_neg  = sq_side[TURN_W];
    assign sq_turn = sq_side[TURN_W-1:0];

    // stage 4: signed speed, scale, add and subtract turn
    logic                     v4_valid_reg;
    logic signed [SUM_W-1:0]  sumr4_reg, suml4_reg;
    logic signed [ROOT_W:0]   root_s, vs;
    logic signed [SUM_W-1:0]  base;

    assign root_s = $signed({1'b0, sq_root});
    assign vs     = sq_neg ? -root_s : root_s;
    assign base   = SUM_W'(vs) * VEL_SCALE_S;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_valid_reg <= 1'b0;
        end else if (en) begin
            v4_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sumr4_reg <= base + SUM_W'(sq_turn);
            suml4_reg <= base - SUM_W'(sq_turn);
        end
    end

    // stage 5: rpm scale
    logic                    v5_valid_reg;
    logic signed [NUM_W-1:0] numr5_reg, numl5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_valid_reg <= 1'b0;
        end else if (en) begin
            v5_valid_reg <= v4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            numr5_reg <= NUM_W'(sumr4_reg) * INV_PI_S;
            numl5_reg <= NUM_W'(suml4_reg) * INV_PI_S;
        end
    end

    // stage 6: magnitude and fixed shift of the dividend
    logic             v6_valid_reg;
    logic [MAG_W-1:0] magr6_reg, magl6_reg;
    logic             sgnr6_reg, sgnl6_reg;
    logic [NUM_W-1:0] absr, absl;

    assign absr = numr5_reg[NUM_W-1] ? NUM_W'(-numr5_reg) : NUM_W'(numr5_reg);
    assign absl = numl5_reg[NUM_W-1] ? NUM_W'(-numl5_reg) : NUM_W'(numl5_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_valid_reg <= 1'b0;
        end else if (en) begin
            v6_valid_reg <= v5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            magr6_reg <= absr[DEN_SHIFT +: MAG_W];
            magl6_reg <= absl[DEN_SHIFT +: MAG_W];
            sgnr6_reg <= numr5_reg[NUM_W-1];
            sgnl6_reg <= numl5_reg[NUM_W-1];
        end
    end

    // divide by wheel radius
    logic [RADIUS_W-1:0] radius_div;
    logic                dl_valid, dr_valid;
    logic [MAG_W-1:0]    dl_quot, dr_quot;
    logic                dl_sgn, dr_sgn;

    assign radius_div = (wheel_radius_reg == '0) ? RADIUS_W'(1) : wheel_radius_reg;

    dws_div #(
        .DIVIDEND_W     (MAG_W),
        .DIVISOR_W      (RADIUS_W),
        .BITS_PER_STAGE (DIV_BITS),
        .SIDE_W         (1)
    ) u_div_left (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (v6_valid_reg),
        .in_dividend  (magl6_reg),
        .in_divisor   (radius_div),
        .in_side      (sgnl6_reg),
        .out_valid    (dl_valid),
        .out_quotient (dl_quot),
        .out_side     (dl_sgn)
    );

    dws_div #(
        .DIVIDEND_W     (MAG_W),
        .DIVISOR_W      (RADIUS_W),
        .BITS_PER_STAGE (DIV_BITS),
        .SIDE_W         (1)
    ) u_div_right (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (v6_valid_reg),
        .in_dividend  (magr6_reg),
        .in_divisor   (radius_div),
        .in_side      (sgnr6_reg),
        .out_valid    (dr_valid),
        .out_quotient (dr_quot),
        .out_side     (dr_sgn)
    );

    // sign restore and output buffer
    logic     push;
    dws_out_t push_data;
    logic [RPM_W-1:0] ql_ext, qr_ext;

    assign ql_ext = RPM_W'(dl_quot);
    assign qr_ext = RPM_W'(dr_quot);
    assign push   = dl_valid & dr_valid & en;

    always_comb begin
        push_data.left_rpm  = dl_sgn ? $signed(-ql_ext) : $signed(ql_ext);
        push_data.right_rpm = dr_sgn ? $signed(-qr_ext) : $signed(qr_ext);
    end

    dws_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (obuf_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // checks
    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(sq_valid) && $stable(v4_valid_reg) && $stable(dl_valid))
        else $error("pipeline moved during stall");

    a_skid_needs_main: assert property (@(posedge aclk) disable iff (!aresetn)
        obuf_full |-> m_valid)
        else $error("skid entry held with empty output register");

    a_push_to_output: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !m_valid |=> m_valid && (m_data == $past(push_data)))
        else $error("result did not reach empty output register");

    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        dl_valid == dr_valid)
        else $error("left and right divider lanes out of step");

endmodule

[sim/diff_drive_wheel_speed_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Differential drive wheel speed testbench
// Drives velocity commands through the valid/ready input channel under several
// track width and wheel radius settings written over the register port, and
// compares every wheel rpm result with a table entry or an in-bench fixed-point
// calculation. A short directed table covers clamping, sign and extreme cases;
// random commands follow, with random idling on both sides, one long result
// stall and pauses until the pipeline has drained.
// ----------------------------------------------------------------------------
module diff_drive_wheel_speed_tb import dws_pkg::*; ();

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int PIPE_LATENCY  = 21;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int CMDS_PER_SET  = 270;
    localparam int NUM_SETS      = 7;
    localparam int NUM_DIRECTED  = 20;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int PRINT_LIMIT   = 100;

    typedef struct packed {
        logic                    known;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic signed [VEL_W-1:0] wz;
        logic signed [RPM_W-1:0] left_rpm;
        logic signed [RPM_W-1:0] right_rpm;
    } cmd_row_t;

    typedef struct packed {
        logic [TRACK_W-1:0]  track;
        logic [RADIUS_W-1:0] radius;
        logic [31:0]         upper;
    } wheel_set_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    dws_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    dws_out_t              m_data;

    logic [TRACK_W-1:0]  cfg_track;
    logic [RADIUS_W-1:0] cfg_radius;
    dws_out_t            rpm_expected [$];
    dws_out_t            rpm_want;
    cmd_row_t            cmd_table [0:NUM_DIRECTED-1];
    wheel_set_t          wheel_sets [0:NUM_SETS-1];
    int                  mismatches;
    int                  results_checked;
    int                  cmds_sent;
    int                  cycles;
    bit                  tx_burst;
    bit                  rx_burst;

    diff_drive_wheel_speed dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #(CLK_HALF) aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     rpm_expected.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    function automatic longint limit_vel(input longint v);
        if (v > VEL_LIMIT) begin
            return VEL_LIMIT;
        end
        if (v < -VEL_LIMIT) begin
            return -VEL_LIMIT;
        end
        return v;
    endfunction

    function automatic longint floor_sqrt(input longint n);
        longint root;
        longint trial;
        root = 0;
        for (int b = 16; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic dws_out_t predict_wheel_rpm(input dws_in_t cmd);
        longint   vx;
        longint   vy;
        longint   wz;
        longint   speed;
        longint   turn;
        longint   den;
        dws_out_t r;
        vx = limit_vel(longint'(cmd.linear_x));
        vy = limit_vel(longint'(cmd.linear_y));
        wz = limit_vel(longint'(cmd.angular_z));
        speed = floor_sqrt(vx * vx + vy * vy);
        if (vx < 0 || vy < 0) begin
            speed = -speed;
        end
        // zero radius divides as one
        den = 2 * 65536 * ((cfg_radius == '0) ? longint'(1) : longint'(cfg_radius));
        turn = longint'(cfg_track) * wz;
        r.left_rpm  = RPM_W'((speed * VEL_SCALE - turn) * INV_PI_30_Q16 / den);
        r.right_rpm = RPM_W'((speed * VEL_SCALE + turn) * INV_PI_30_Q16 / den);
        return r;
    endfunction

    function automatic logic [VEL_W-1:0] rand_vel();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            return VEL_W'(int'($urandom_range(0, 2 * VEL_LIMIT)) - VEL_LIMIT);
        end else if (kind <= 7) begin
            return VEL_W'($urandom);
        end else if (kind == 8) begin
            return VEL_W'(int'($urandom_range(0, 32)) - 16);
        end
        case ($urandom_range(0, 6))
            0: return VEL_W'(VEL_LIMIT);
            1: return VEL_W'(-VEL_LIMIT);
            2: return VEL_W'(VEL_LIMIT + 1);
            3: return VEL_W'(-VEL_LIMIT - 1);
            4: return 16'h7fff;
            5: return 16'h8000;
            default: return '0;
        endcase
    endfunction

    task automatic apb_xfer(input logic wr, input dws_reg_idx_t idx,
                            input logic [CFG_DATA_W-1:0] data,
                            output logic [CFG_DATA_W-1:0] rd);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CFG_ADDR_W'(idx) << REG_SEL_BIT;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_regs();
        logic [CFG_DATA_W-1:0] rd;
        apb_xfer(1'b0, REG_TRACK_WIDTH, '0, rd);
        if (rd !== CFG_DATA_W'(cfg_track)) begin
            report_mismatch($sformatf("track width reads %0d, expected %0d", rd, cfg_track));
        end
        apb_xfer(1'b0, REG_WHEEL_RADIUS, '0, rd);
        if (rd !== CFG_DATA_W'(cfg_radius)) begin
            report_mismatch($sformatf("wheel radius reads %0d, expected %0d", rd, cfg_radius));
        end
    endtask

    task automatic set_wheels(input wheel_set_t ws);
        logic [CFG_DATA_W-1:0] rd;
        // upper bits beyond the register width are dropped
        apb_xfer(1'b1, REG_TRACK_WIDTH, ws.upper | CFG_DATA_W'(ws.track), rd);
        cfg_track = ws.track;
        apb_xfer(1'b1, REG_WHEEL_RADIUS, ws.upper | CFG_DATA_W'(ws.radius), rd);
        cfg_radius = ws.radius;
        check_regs();
    endtask

    task automatic send_cmd(input dws_in_t cmd, input dws_out_t want);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 16);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= cmd;
        do @(posedge aclk); while (!s_ready);
        rpm_expected.push_back(want);
        cmds_sent++;
        if (cmds_sent % 50 == 0) begin
            tx_burst = ($urandom_range(0, 3) == 0);
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (rpm_expected.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (rpm_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected result left %0d right %0d",
                                          m_data.left_rpm, m_data.right_rpm));
            end else begin
                rpm_want = rpm_expected.pop_front();
                if (m_data.left_rpm !== rpm_want.left_rpm) begin
                    report_mismatch($sformatf("left_rpm %0d, expected %0d",
                                              m_data.left_rpm, rpm_want.left_rpm));
                end
                if (m_data.right_rpm !== rpm_want.right_rpm) begin
                    report_mismatch($sformatf("right_rpm %0d, expected %0d",
                                              m_data.right_rpm, rpm_want.right_rpm));
                end
            end
            results_checked++;
        end
    end

    // result side ready with random stalls and one long hold-off
    initial begin
        int  gap;
        bit  held;
        int  seen;
        held = 1'b0;
        seen = 0;
        @(posedge aresetn);
        @(negedge aclk);
        m_ready <= 1'b1;
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 16);
            if (!held && seen >= HOLD_AT) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
                m_ready <= 1'b1;
            end
            do @(posedge aclk); while (!(m_valid && m_ready));
            seen++;
            if (seen % 50 == 0) begin
                rx_burst = ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial begin
        dws_in_t  cmd;
        dws_out_t want;
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_valid  = 1'b0;
        s_data   = '0;
        m_ready  = 1'b0;
        cycles   = 0;
        mismatches      = 0;
        results_checked = 0;
        cmds_sent       = 0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        cfg_track  = TRACK_W'(TRACK_RESET);
        cfg_radius = RADIUS_W'(RADIUS_RESET);

        cmd_table = '{
            '{1'b1, 16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0},
            '{1'b0, 16'sd25600, 16'sd0, 16'sd0, 32'sd0, 32'sd0},
            '{1'b0, -16'sd25600, 16'sd0, 16'sd0, 32'sd0, 32'sd0},
            '{1'b0, 16'sd0, 16'sd25600, 16'sd0, 32'sd0, 32'sd0},
            '{1'b0, 16'sd0, -16'sd25600, 16'sd0, 32'sd0, 32'sd0},
            '{1'b0, 16'sd0, 16'sd0, 16'sd25600, 32'sd0, 32'sd0},
            '{1'b0, 16'sd0, 16'sd0, -16'sd25600, 32'sd0, 32'sd0},
            '{1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sd0, 32'sd0},
            '{1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 32'sd0, 32'sd0},
            '{1'b0, 16'sd25601, -16'sd25601, 16'sd1, 32'sd0, 32'sd0},
            '{1'b0, 16'sd25600, 16'sd25600, 16'sd25600, 32'sd0, 32'sd0},
            '{1'b0, -16'sd25600, -16'sd25600, -16'sd25600, 32'sd0, 32'sd0},
            '{1'b0, 16'sd100, -16'sd1, 16'sd0, 32'sd0, 32'sd0},
            '{1'b0, -16'sd1, 16'sd100, 16'sd0, 32'sd0, 32'sd0},
            '{1'b0, 16'sd1, 16'sd1, -16'sd1, 32'sd0, 32'sd0},
            '{1'b0, 16'sh5555, 16'sh2aaa, 16'shd555, 32'sd0, 32'sd0},
            '{1'b0, 16'shaaaa, 16'sh5555, 16'sh2aaa, 32'sd0, 32'sd0},
            '{1'b0, 16'sd3, 16'sd4, -16'sd3, 32'sd0, 32'sd0},
            '{1'b0, -16'sd25599, 16'sd25599, 16'sd0, 32'sd0, 32'sd0},
            '{1'b0, 16'sd0, 16'sd0, 16'sd1, 32'sd0, 32'sd0}
        };

        wheel_sets = '{
            '{12'd4095, 10'd1023, 32'h0},
            '{12'd1, 10'd1, 32'h0},
            '{12'd0, 10'd0, 32'h0},
            '{12'd4095, 10'd1, 32'habcd_e000},
            '{12'd1, 10'd1023, 32'h0},
            '{TRACK_W'($urandom_range(1, 4095)), RADIUS_W'($urandom_range(1, 1023)), 32'h0},
            '{12'd620, 10'd65, 32'h0}
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        check_regs();
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            cmd.linear_x  = cmd_table[i].vx;
            cmd.linear_y  = cmd_table[i].vy;
            cmd.angular_z = cmd_table[i].wz;
            if (cmd_table[i].known) begin
                want.left_rpm  = cmd_table[i].left_rpm;
                want.right_rpm = cmd_table[i].right_rpm;
            end else begin
                want = predict_wheel_rpm(cmd);
            end
            send_cmd(cmd, want);
        end
        drain_results();

        for (int s = 0; s < NUM_SETS; s++) begin
            set_wheels(wheel_sets[s]);
            for (int i = 0; i < CMDS_PER_SET; i++) begin
                if (s == 3 && i == CMDS_PER_SET / 2) begin
                    drain_results();
                end
                cmd.linear_x  = rand_vel();
                cmd.linear_y  = rand_vel();
                cmd.angular_z = rand_vel();
                send_cmd(cmd, predict_wheel_rpm(cmd));
            end
            drain_results();
        end

        repeat (2 * PIPE_LATENCY) @(posedge aclk);
        $display("sent %0d velocity commands (%0d directed) across %0d wheel settings",
                 cmds_sent, NUM_DIRECTED, NUM_SETS + 1);
        $display("checked %0d wheel speed results, %0d mismatches", results_checked,
                 mismatches);
        if (mismatches == 0 && rpm_expected.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
